@@ rtl/core/particle_slot_lifetime_manager_unit_defines.svh @@
// assertion macros for the particle slot lifetime manager
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef PARTICLE_SLOT_LIFETIME_MANAGER_UNIT_DEFINES_SVH
`define PARTICLE_SLOT_LIFETIME_MANAGER_UNIT_DEFINES_SVH

// property checked on every clock, off while reset is low
`define PSLM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("particle slot manager check failed");

// condition that must never be true
`define PSLM_ASSERT_NEVER(lbl, expr) \
  `PSLM_ASSERT(lbl, !(expr))

`endif

@@ rtl/core/pslm_pkg.sv @@
// shared types and constants of the particle slot lifetime manager
// no dependencies
package pslm_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned TIME_W = 20;

  // item kind codes
  localparam logic KIND_EMIT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] new_lifetime;
    logic [TIME_W-1:0] tick_delta;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_used;
    logic              evicted;
    logic [CNT_W-1:0]  expired_count;
    logic [CNT_W-1:0]  active_count;
    logic [SLOT_W-1:0] window_start;
    logic [CNT_W-1:0]  window_size;
  } result_t;

  // outcome of aging one slot
  typedef struct packed {
    logic              retire;
    logic [TIME_W-1:0] remain;
  } age_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_TICK,
    ST_TRIM,
    ST_FINISH
  } pslm_state_e;

endpackage

@@ rtl/core/particle_slot_lifetime_manager_unit.sv @@
// particle slot lifetime manager, top level
// depends on pslm_pkg, pslm_ram, pslm_age and the assertion macro header
//
// usage:
//  - command channel: an item (emit or tick) is taken when start is high and busy is
//    low; busy stays high until the result has been formed
//  - result channel: done_o pulses for one cycle with result_o; the receiver cannot
//    stall, so the result must be captured in that cycle
//  - a new item may be issued in the same cycle that done_o is high
//  - emit: the slot is written in the emit step when the window has room or every slot
//    is live; when the full window holds free slots a scan walks one slot per cycle
//  - tick: the single aging unit visits one window slot per cycle through the time
//    ram read port; if the last window slot retires, a trim step then drops trailing
//    free slots off the window end one per cycle
//  - reset clears every active mark, the window and the live count at once; time
//    values are not cleared, they are only read for active slots
`include "particle_slot_lifetime_manager_unit_defines.svh"

module particle_slot_lifetime_manager_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pslm_pkg::item_t   item_i,
  output logic              done_o,
  output pslm_pkg::result_t result_o
);
  import pslm_pkg::*;

  // sequencer and window state
  pslm_state_e       state_q, state_d;
  logic [SLOTS-1:0]  active_q, active_d;
  logic [SLOT_W-1:0] start_q, start_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [CNT_W-1:0]  live_q, live_d;

  // per transaction working registers
  logic [TIME_W-1:0] life_q, life_d;
  logic [TIME_W-1:0] delta_q, delta_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0] first_q, first_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic              trim_q, trim_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              evict_q, evict_d;
  logic [CNT_W-1:0]  expired_q, expired_d;

  // result register
  logic              done_q, done_d;
  result_t           result_q, result_d;

  // time ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  age_res_t          age_res;

  // handy slot indexes
  logic [SLOT_W-1:0] append_slot;
  logic [SLOT_W-1:0] scan_slot;
  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] read_slot;

  assign append_slot = start_q + size_q[SLOT_W-1:0];
  assign scan_slot   = start_q + idx_q[SLOT_W-1:0];
  assign last_slot   = start_q + size_q[SLOT_W-1:0] - SLOT_W'(1);
  assign read_slot   = first_q + idx_q[SLOT_W-1:0];

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  pslm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the one subtract and compare unit, fed one slot per cycle
  pslm_age u_age (
    .time_i  (ram_rdata),
    .delta_i (delta_q),
    .res_o   (age_res)
  );

  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    start_d   = start_q;
    size_d    = size_q;
    live_d    = live_q;
    life_d    = life_q;
    delta_d   = delta_q;
    idx_d     = idx_q;
    first_d   = first_q;
    count_d   = count_q;
    rd_vld_d  = rd_vld_q;
    rd_slot_d = rd_slot_q;
    trim_d    = trim_q;
    slot_d    = slot_q;
    evict_d   = evict_q;
    expired_d = expired_q;
    done_d    = 1'b0;
    result_d  = result_q;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = life_q;
    ram_raddr = read_slot;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          life_d    = item_i.new_lifetime;
          delta_d   = item_i.tick_delta;
          slot_d    = '0;
          evict_d   = 1'b0;
          expired_d = '0;
          trim_d    = 1'b0;
          rd_vld_d  = 1'b0;
          idx_d     = '0;
          first_d   = start_q;
          count_d   = size_q;
          if (item_i.kind == KIND_TICK) begin
            state_d = ST_TICK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (size_q < CNT_W'(SLOTS)) begin
          // room left: append at the window end
          ram_we                = 1'b1;
          ram_waddr             = append_slot;
          slot_d                = append_slot;
          evict_d               = active_q[append_slot];
          active_d[append_slot] = 1'b1;
          size_d                = size_q + CNT_W'(1);
          if (!active_q[append_slot] && (live_q < CNT_W'(SLOTS))) begin
            live_d = live_q + CNT_W'(1);
          end
          state_d = ST_FINISH;
        end else if (live_q < CNT_W'(SLOTS)) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end else begin
          // every slot live: evict the oldest and move the start on
          ram_we            = 1'b1;
          ram_waddr         = start_q;
          slot_d            = start_q;
          evict_d           = active_q[start_q];
          active_d[start_q] = 1'b1;
          start_d           = start_q + SLOT_W'(1);
          state_d           = ST_FINISH;
        end
      end

      ST_SCAN: begin
        if (idx_q == CNT_W'(SLOTS)) begin
          // no free slot after all: overwrite in place at the start
          ram_we            = 1'b1;
          ram_waddr         = start_q;
          slot_d            = start_q;
          evict_d           = active_q[start_q];
          active_d[start_q] = 1'b1;
          state_d           = ST_FINISH;
        end else if (!active_q[scan_slot]) begin
          ram_we              = 1'b1;
          ram_waddr           = scan_slot;
          slot_d              = scan_slot;
          evict_d             = 1'b0;
          active_d[scan_slot] = 1'b1;
          if (live_q < CNT_W'(SLOTS)) begin
            live_d = live_q + CNT_W'(1);
          end
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end

      ST_TICK: begin
        // issue the read of the next window slot
        if (idx_q < count_q) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = read_slot;
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          rd_vld_d = 1'b0;
        end
        // age the slot whose time arrived this cycle
        if (rd_vld_q && active_q[rd_slot_q]) begin
          if (!age_res.retire) begin
            ram_we    = 1'b1;
            ram_waddr = rd_slot_q;
            ram_wdata = age_res.remain;
          end else begin
            active_d[rd_slot_q] = 1'b0;
            expired_d           = expired_q + CNT_W'(1);
            if (live_q != '0) begin
              live_d = live_q - CNT_W'(1);
            end
            if (rd_slot_q == start_q) begin
              start_d = start_q + SLOT_W'(1);
              if (size_q != '0) begin
                size_d = size_q - CNT_W'(1);
              end
            end else if ((size_q != '0) && (rd_slot_q == last_slot)) begin
              trim_d = 1'b1;
            end
          end
        end
        if (!rd_vld_q && (idx_q >= count_q)) begin
          state_d = trim_q ? ST_TRIM : ST_FINISH;
        end
      end

      ST_TRIM: begin
        // drop trailing free slots one per cycle
        if ((size_q != '0) && !active_q[last_slot]) begin
          size_d = size_q - CNT_W'(1);
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        done_d                 = 1'b1;
        result_d.slot_used     = slot_q;
        result_d.evicted       = evict_q;
        result_d.expired_count = expired_q;
        result_d.active_count  = live_q;
        result_d.window_start  = start_q;
        result_d.window_size   = size_q;
        state_d                = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      start_q  <= '0;
      size_q   <= '0;
      live_q   <= '0;
      rd_vld_q <= 1'b0;
      trim_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      start_q  <= start_d;
      size_q   <= size_d;
      live_q   <= live_d;
      rd_vld_q <= rd_vld_d;
      trim_q   <= trim_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    life_q    <= life_d;
    delta_q   <= delta_d;
    idx_q     <= idx_d;
    first_q   <= first_d;
    count_q   <= count_d;
    rd_slot_q <= rd_slot_d;
    slot_q    <= slot_d;
    evict_q   <= evict_d;
    expired_q <= expired_d;
    result_q  <= result_d;
  end

  // live count tracks the active marks between transactions
  `PSLM_ASSERT(a_live_matches_marks, (state_q == ST_IDLE) |-> (live_q == CNT_W'($countones(active_q))))
  // window never grows past the ring
  `PSLM_ASSERT_NEVER(a_size_in_range, size_q > CNT_W'(SLOTS))
  // an accepted transaction raises busy
  `PSLM_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  // a result is announced only on leaving the finish step
  `PSLM_ASSERT(a_done_after_finish, done_o |-> ($past(state_q) == ST_FINISH))

endmodule

@@ rtl/core/pslm_ram.sv @@
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module pslm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pslm_age.sv @@
// shared aging unit: subtracts the tick delta from one slot's time left
// depends on pslm_pkg
module pslm_age (
  input  logic [pslm_pkg::TIME_W-1:0] time_i,
  input  logic [pslm_pkg::TIME_W-1:0] delta_i,
  output pslm_pkg::age_res_t          res_o
);
  import pslm_pkg::*;

  logic [TIME_W:0] diff;

  assign diff = {1'b0, time_i} - {1'b0, delta_i};

  // retire on borrow or exact zero
  assign res_o.retire = diff[TIME_W] | (diff[TIME_W-1:0] == '0);
  assign res_o.remain = diff[TIME_W-1:0];

endmodule

@@ verif/particle_slot_lifetime_manager_unit_tb.sv @@
// testbench for the particle slot lifetime manager: directed and random emit / tick traffic
// predicts every result with its own model of the slot ring and checks it field by field
// depends on pslm_pkg and the particle_slot_lifetime_manager_unit rtl
`timescale 1ns / 100ps

module particle_slot_lifetime_manager_unit_tb;
  import pslm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // longest tick: a full window walk plus a full tail trim, with margin
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // traffic mixes for the random part
  typedef enum int unsigned {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } traffic_mix_e;

  // ring model plus the queue of results still owed by the block
  class slot_ring_scoreboard;
    bit                slot_live [SLOTS];
    logic [TIME_W-1:0] slot_time [SLOTS];
    int unsigned       head;
    int unsigned       span;
    int unsigned       live;
    result_t           owed_results [$];
    int unsigned       mismatch_cnt;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_time[i] = '0;
      end
      head = 0;
      span = 0;
      live = 0;
      mismatch_cnt = 0;
    endfunction

    function void arm_slot(int unsigned s, logic [TIME_W-1:0] life);
      slot_live[s] = 1'b1;
      slot_time[s] = life;
    endfunction

    function result_t predict_step(item_t it);
      result_t     res;
      int unsigned s;
      int unsigned first;
      int unsigned count;
      int unsigned expired;
      bit          found;
      res = '0;
      s = 0;
      expired = 0;
      if (it.kind == KIND_EMIT) begin
        if (span < SLOTS) begin
          // window has room: append behind the last slot
          s = (head + span) % SLOTS;
          res.evicted = slot_live[s];
          arm_slot(s, it.new_lifetime);
          span++;
          if (!res.evicted && live < SLOTS) live++;
        end else if (live < SLOTS) begin
          // full window with holes: first free slot in ring order
          found = 1'b0;
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (!slot_live[(head + i) % SLOTS]) begin
              s = (head + i) % SLOTS;
              found = 1'b1;
            end
          end
          if (found) begin
            arm_slot(s, it.new_lifetime);
            if (live < SLOTS) live++;
          end else begin
            s = head;
            res.evicted = slot_live[s];
            arm_slot(s, it.new_lifetime);
          end
        end else begin
          // every slot live: evict the oldest and advance
          s = head;
          res.evicted = slot_live[s];
          arm_slot(s, it.new_lifetime);
          head = (head + 1) % SLOTS;
        end
        res.slot_used = SLOT_W'(s);
      end else begin
        first = head;
        count = span;
        for (int i = 0; i < count; i++) begin
          s = (first + i) % SLOTS;
          if (!slot_live[s]) continue;
          if (slot_time[s] > it.tick_delta) begin
            slot_time[s] = slot_time[s] - it.tick_delta;
            continue;
          end
          slot_live[s] = 1'b0;
          expired++;
          if (live > 0) live--;
          if (s == head) begin
            head = (head + 1) % SLOTS;
            if (span > 0) span--;
          end else if (span > 0 && s == (head + span - 1) % SLOTS) begin
            // trim free slots off the tail
            while (span > 0 && !slot_live[(head + span - 1) % SLOTS]) span--;
          end
        end
        res.expired_count = CNT_W'(expired);
      end
      res.active_count = CNT_W'(live);
      res.window_start = SLOT_W'(head);
      res.window_size  = CNT_W'(span);
      return res;
    endfunction

    function void note_item(item_t it);
      owed_results.push_back(predict_step(it));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_cnt++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatch_cnt++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("slot_used", want.slot_used, got.slot_used);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("expired_count", want.expired_count, got.expired_count);
      compare_field("active_count", want.active_count, got.active_count);
      compare_field("window_start", want.window_start, got.window_start);
      compare_field("window_size", want.window_size, got.window_size);
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  slot_ring_scoreboard sb;
  int unsigned         cycle_cnt = 0;

  particle_slot_lifetime_manager_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard: a hung block ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("particle_slot_lifetime_manager_unit: mismatch");
      $finish;
    end
  end

  // result monitor: done_o is a one-cycle strobe, the block never waits for us
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // lifetime mix: extremes, full-range values, long-lived and short-lived particles
  function logic [TIME_W-1:0] pick_lifetime(int unsigned long_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return TIME_MAX;
    if (r < 12) return TIME_W'($urandom);
    if (r < 12 + long_pct) return TIME_W'($urandom_range(5000, TIME_MAX));
    return TIME_W'($urandom_range(1, 300));
  endfunction

  function logic [TIME_W-1:0] pick_delta(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 7) return TIME_MAX;
    if (r < 11) return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, hi));
  endfunction

  // unused field of each transaction carries random bits
  function item_t emit_item(logic [TIME_W-1:0] life);
    item_t it;
    it.kind         = KIND_EMIT;
    it.new_lifetime = life;
    it.tick_delta   = TIME_W'($urandom);
    return it;
  endfunction

  function item_t tick_item(logic [TIME_W-1:0] delta);
    item_t it;
    it.kind         = KIND_TICK;
    it.new_lifetime = TIME_W'($urandom);
    it.tick_delta   = delta;
    return it;
  endfunction

  // fill: mostly emits of long-lived particles, so the ring fills and evicts
  // churn: balanced traffic that punches holes for the free-slot scan
  // drain: mostly ticks with larger deltas, emptying the window
  function item_t random_item(traffic_mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 10) return tick_item(pick_delta(64));
        return emit_item(pick_lifetime(60));
      end
      MIX_CHURN: begin
        if (r < 35) return tick_item(pick_delta(200));
        return emit_item(pick_lifetime(40));
      end
      default: begin
        if (r < 70) return tick_item(pick_delta(5000));
        return emit_item(pick_lifetime(20));
      end
    endcase
  endfunction

  // sender gap: start is dropped about one time in five
  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // present one transaction and hold it until the block takes it
  task automatic send_item(item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  initial begin
    item_t        directed [$];
    traffic_mix_e mix;
    int unsigned  sent;
    int unsigned  run_len;
    sb     = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tick on an empty window
    directed.push_back(tick_item(TIME_W'(5)));
    // zero lifetime retires on the next tick even with zero delta
    directed.push_back(emit_item('0));
    directed.push_back(tick_item('0));
    // lifetime extremes, then a hole in the middle of the window
    directed.push_back(emit_item(TIME_MAX));
    directed.push_back(emit_item(TIME_W'(1)));
    directed.push_back(emit_item(TIME_W'(3)));
    directed.push_back(tick_item(TIME_W'(1)));
    // last slot retires and the free slot before it is trimmed
    directed.push_back(tick_item(TIME_W'(2)));
    directed.push_back(emit_item(TIME_MAX - TIME_W'(1)));
    directed.push_back(emit_item(TIME_W'(1)));
    // maximum delta retires everything, window collapses from the start
    directed.push_back(tick_item(TIME_MAX));
    directed.push_back(emit_item(TIME_W'(2)));
    directed.push_back(tick_item(TIME_W'(1)));
    directed.push_back(tick_item(TIME_W'(1)));
    directed.push_back(emit_item(TIME_MAX));
    directed.push_back(tick_item(TIME_MAX - TIME_W'(1)));
    directed.push_back(tick_item(TIME_W'(1)));

    foreach (directed[i]) begin
      maybe_idle(1'b1);
      send_item(directed[i]);
    end

    // random part in runs of one traffic mix, with a stretch of back-to-back items in the middle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = traffic_mix_e'($urandom_range(0, 2));
      run_len = $urandom_range(40, 120);
      for (int j = 0; j < run_len && sent < RANDOM_ITEMS; j++) begin
        maybe_idle(!(sent >= 600 && sent < 900));
        send_item(random_item(mix));
        sent++;
      end
    end
    start <= 1'b0;

    // wait for every owed result, then watch for stray ones
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatch_cnt == 0) begin
      $display("particle_slot_lifetime_manager_unit: match");
    end else begin
      $display("particle_slot_lifetime_manager_unit: mismatch");
    end
    $finish;
  end

endmodule
